/* sv/modexp_fermat_prime_macros.svh */
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODEXP_FERMAT_PRIME_MACROS_SVH
`define MODEXP_FERMAT_PRIME_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mfp_pkg.sv */
// Types, constants and the modulo-65537 fold used by the exponentiation block.
package mfp_pkg;

	localparam int unsigned RES_W = 17;
	localparam logic [17:0] FERMAT_MOD = 18'd65537;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_RUN,
		ST_FINISH
	} mfp_state_t;

	// Since 2^16 is -1 modulo 65537, hi * 2^16 + lo folds to lo - hi.
	// With hi at most 65536 the difference needs one correction at most.
	function automatic logic [RES_W-1:0] mfp_fold(input logic [15:0] lo,
			input logic [16:0] hi);
		logic [17:0] diff;
		logic [17:0] fixed;
		diff  = {2'b00, lo} - {1'b0, hi};
		fixed = diff[17] ? (diff + FERMAT_MOD) : diff;
		return fixed[RES_W-1:0];
	endfunction

endpackage

/* sv/modexp_fermat_prime.sv */
// Modular exponentiation modulo 65537 by right-to-left square-and-multiply.
// An item is taken only in the idle state and then passes the reduce, run and finish
// states in order; no new item is taken until the finish state hands its result on.
// The exponent leaves its shift register one bit per cycle; that scan sets the rate.
// A finished result waits in its own register, so the next item can be taken meanwhile.
// arst_n clears the sequencer and the output valid flag at once; data registers hold.
`include "modexp_fermat_prime_macros.svh"

module modexp_fermat_prime
	import mfp_pkg::*;
#(
	parameter int unsigned EXP_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [31:0] base_value, [63:32] exponent_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [16:0] power_residue, [23:17] zero
);

	// The bit counter must be able to hold EXP_BITS itself.
	localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);

	mfp_state_t state_q;
	mfp_state_t state_d;

	logic                 in_accept;
	logic                 load_out;
	logic                 out_valid_q;
	logic [RES_W-1:0]     res_q;

	// Working registers of one item.
	logic [31:0]          base_q;
	logic [EXP_BITS-1:0]  exp_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [RES_W-1:0]     acc_q;
	logic [RES_W-1:0]     sq_q;

	logic [63:0]          exp_ext;
	logic [32:0]          prod_acc;
	logic [32:0]          prod_sq;

	// The exponent is widened to the largest scan width and then trimmed, so
	// bits at EXP_BITS and above are dropped and missing bits read as zero.
	assign exp_ext = {32'd0, s_axis_tdata[63:32]};

	// Both operands stay below 65537, so each product fits in 33 bits.
	assign prod_acc = {16'd0, acc_q} * {16'd0, sq_q};
	assign prod_sq  = {16'd0, sq_q} * {16'd0, sq_q};

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// Handshake outputs of the sequencer. The result moves to the output
	// register only once that register is empty or being emptied.
	always_comb begin
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_REDUCE, ST_RUN: begin
			end
			ST_FINISH: begin
				load_out = !out_valid_q || m_axis_tready;
			end
		endcase
	end

	assign in_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath. In the reduce cycle the raw base is folded once, which
	// brings any 32-bit value into 0..65536. Each run cycle then consumes
	// the lowest exponent bit: a set bit multiplies it into the accumulator,
	// and the running square is squared on every bit.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					base_q <= s_axis_tdata[31:0];
					exp_q  <= exp_ext[EXP_BITS-1:0];
				end
			end
			ST_REDUCE: begin
				sq_q  <= mfp_fold(base_q[15:0], {1'b0, base_q[31:16]});
				acc_q <= RES_W'(1);
				cnt_q <= CNT_W'(EXP_BITS);
			end
			ST_RUN: begin
				if (exp_q[0]) begin
					acc_q <= mfp_fold(prod_acc[15:0], prod_acc[32:16]);
				end
				sq_q  <= mfp_fold(prod_sq[15:0], prod_sq[32:16]);
				exp_q <= exp_q >> 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_FINISH: begin
				if (load_out) begin
					res_q <= acc_q;
				end
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, res_q};

	`MFP_ASSERT_NEXT(a_accept_starts_reduce, clk, arst_n, in_accept, state_q == ST_REDUCE, "accepted item did not start the base reduction")
	`MFP_ASSERT_NOW(a_run_operands_reduced, clk, arst_n, state_q == ST_RUN, (acc_q <= RES_W'(65536)) && (sq_q <= RES_W'(65536)), "operand left the residue range during the scan")
	`MFP_ASSERT_NOW(a_result_from_finish, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_FINISH, "result appeared without a finished scan")
	`MFP_ASSERT_NEXT(a_last_bit_finishes, clk, arst_n, (state_q == ST_RUN) && (cnt_q == CNT_W'(1)), state_q == ST_FINISH, "scan did not end after the last exponent bit")
	`MFP_ASSERT_NOW(a_result_in_range, clk, arst_n, out_valid_q, res_q <= RES_W'(65536), "result item is not a residue modulo 65537")

endmodule

/* tb/modexp_fermat_prime_tb.sv */
// Self-checking testbench for the modulo-65537 exponentiation block with random stream idling.
module modexp_fermat_prime_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned EXP_BITS = 32;
	localparam int unsigned RES_W = mfp_pkg::RES_W;
	localparam logic [63:0] PRIME = 64'd65537;

	// Random items that remain when the tail without idling starts.
	localparam int TAIL_ITEMS = 150;
	localparam int RANDOM_ITEMS = 1130;
	// The output side holds off once, after HOLD_AT items; HOLD_CYCLES sets how long.
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT = 300;

	// One input item. The packed layout matches s_axis_tdata: base in the low word.
	typedef struct packed {
		logic [31:0] exponent_value;
		logic [31:0] base_value;
	} power_item_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [63:0]      s_axis_tdata;   // [31:0] base_value, [63:32] exponent_value
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [23:0]      m_axis_tdata;   // [16:0] power_residue, [23:17] zero

	power_item_t      pending_items[$];
	logic [RES_W-1:0] expected_residues[$];

	bit  input_taken;
	int  items_accepted;
	int  results_checked;
	int  mismatches;
	int  idle_chance;
	int  send_gap;
	int  stall_left;
	int  hold_left;
	bit  hold_done;
	int  zero_exponents;
	int  prime_multiples;

	modexp_fermat_prime #(
		.EXP_BITS(EXP_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Right-to-left square-and-multiply: the running square is base^(2^i), and it
	// is folded into the product whenever exponent bit i is set. Only the low
	// EXP_BITS bits of the exponent take part.
	function automatic logic [RES_W-1:0] fermat_power(input logic [31:0] base,
			input logic [31:0] expo);
		logic [63:0] product;
		logic [63:0] square;
		product = 64'd1;
		square  = {32'd0, base} % PRIME;
		for (int i = 0; i < EXP_BITS && i < 32; i++) begin
			if (expo[i]) begin
				product = (product * square) % PRIME;
			end
			square = (square * square) % PRIME;
		end
		return product[RES_W-1:0];
	endfunction

	task automatic add_item(input logic [31:0] base, input logic [31:0] expo);
		power_item_t item;
		item.base_value     = base;
		item.exponent_value = expo;
		pending_items.push_back(item);
		if (expo == 32'd0) begin
			zero_exponents++;
		end
		if ({32'd0, base} % PRIME == 64'd0) begin
			prime_multiples++;
		end
	endtask

	// Random items in several flavors. Four in ten are fully random; the others steer
	// into the special cases: bases that vanish modulo the prime, bases of +1 and
	// -1, zero, sparse and dense exponents, small bases and exponents, and the
	// primitive root 3 whose powers sweep the whole multiplicative group.
	task automatic add_random_items(input int count);
		logic [31:0] base;
		logic [31:0] expo;
		for (int n = 0; n < count; n++) begin
			base = $urandom();
			expo = $urandom();
			case ($urandom_range(0, 9))
				4: begin
					base = 32'(65537 * $urandom_range(0, 65535));
				end
				5: begin
					expo = 32'd0;
				end
				6: begin
					base = $urandom_range(0, 65536);
					expo = $urandom_range(0, 70000);
				end
				7: begin
					base = 32'(65537 * $urandom_range(0, 65534)
						+ ($urandom_range(0, 1) ? 65536 : 1));
				end
				8: begin
					expo = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
						: (32'hFFFF_FFFF >> $urandom_range(0, 31));
				end
				9: begin
					base = 32'd3;
				end
				default: begin
				end
			endcase
			add_item(base, expo);
		end
	endtask

	// Sender. A new item goes out once the previous one was taken at the last
	// rising edge; after some items a burst of idle cycles follows. The last
	// TAIL_ITEMS items are sent back to back.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || input_taken) begin
				if (send_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					send_gap--;
				end else if (pending_items.size() > 0) begin
					s_axis_tdata  <= pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					if (pending_items.size() >= TAIL_ITEMS
							&& $urandom_range(0, 99) < idle_chance) begin
						send_gap = $urandom_range(1, 19);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Besides the short random stalls it holds off once for a long
	// stretch, so that a finished result waits, the next one completes behind
	// it, and the block has to refuse further input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && items_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (pending_items.size() >= TAIL_ITEMS
					&& $urandom_range(0, 99) < idle_chance) begin
				stall_left = $urandom_range(1, 19) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Monitor. Accepted inputs push their predicted residue; accepted results are
	// checked against the oldest prediction in order.
	always @(posedge clk) begin
		if (arst_n) begin
			input_taken = s_axis_tvalid && s_axis_tready;
			if (input_taken) begin
				expected_residues.push_back(fermat_power(s_axis_tdata[31:0],
					s_axis_tdata[63:32]));
				items_accepted++;
				// Every 64 items the idling density changes; zero gives calm stretches.
				if (items_accepted % 64 == 0) begin
					case ($urandom_range(0, 2))
						0: idle_chance = 0;
						1: idle_chance = 15;
						default: idle_chance = 40;
					endcase
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_residues.size() == 0) begin
					$display("%0t: unexpected result: expected none, got residue %0d",
						$time, m_axis_tdata[RES_W-1:0]);
					mismatches++;
				end else begin
					logic [RES_W-1:0] want;
					want = expected_residues.pop_front();
					if (m_axis_tdata[RES_W-1:0] !== want) begin
						$display("%0t: result %0d: expected residue %0d, got %0d",
							$time, results_checked, want, m_axis_tdata[RES_W-1:0]);
						mismatches++;
					end
				end
				results_checked++;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		idle_chance   = 15;

		// Directed items: identities, the extremes of both fields, bases that
		// reduce to zero, and powers that land on 0, 1 and -1 (65536).
		add_item(32'd0, 32'd0);
		add_item(32'd65537, 32'd0);
		add_item(32'hFFFF_FFFF, 32'd0);
		add_item(32'd0, 32'd1);
		add_item(32'd65537, 32'd5);
		add_item(32'd131074, 32'hFFFF_FFFF);
		add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_item(32'hFFFF_FFFF, 32'd1);
		add_item(32'd1, 32'hFFFF_FFFF);
		add_item(32'd65536, 32'd1);
		add_item(32'd65536, 32'd2);
		add_item(32'd65536, 32'hFFFF_FFFF);
		add_item(32'd2, 32'd16);
		add_item(32'd2, 32'd32);
		add_item(32'd3, 32'd32768);
		add_item(32'd3, 32'd65536);
		add_item(32'd3, 32'h8000_0000);
		add_item(32'd65538, 32'd1);
		add_item(32'd65535, 32'd65535);
		add_item(32'h8000_0000, 32'h5555_5555);
		add_item(32'h5555_5555, 32'hAAAA_AAAA);
		add_item(32'hAAAA_AAAA, 32'h5555_5555);
		add_random_items(RANDOM_ITEMS);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do begin
			@(negedge clk);
		end while (pending_items.size() > 0 || s_axis_tvalid
			|| expected_residues.size() > 0);
		// Any stray result would appear within one computation time.
		repeat (2 * EXP_BITS + 10) @(posedge clk);

		$display("Checked %0d results of %0d items, %0d with a zero exponent and %0d",
			results_checked, items_accepted, zero_exponents, prime_multiples);
		$display("with a base divisible by 65537, under random idling and a %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timeout after %0t with %0d results outstanding", $time,
			expected_residues.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/mfp_pkg.sv
sv/modexp_fermat_prime.sv
tb/modexp_fermat_prime_tb.sv
